// File: rtl/mipmap_box_filter_chain_assert.svh
// Assertion macros used by the mip chain cascade engine
`ifndef MIPMAP_BOX_FILTER_CHAIN_ASSERT_SVH
`define MIPMAP_BOX_FILTER_CHAIN_ASSERT_SVH
`ifndef SYNTHESIS
`define MBF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mip chain assertion failed");
`define MBF_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("mip chain forbidden condition");
`else
`define MBF_ASSERT(lbl, prop)
`define MBF_ASSERT_NEVER(lbl, expr)
`endif
`endif

// File: rtl/mbfc_pkg.sv
// Shared types, constants and channel arithmetic for the mip chain filter
package mbfc_pkg;

  localparam int unsigned DefMaxWidth  = 4096;
  localparam int unsigned DefMaxLevels = 12;
  localparam int unsigned HeightLimit  = 4096;
  localparam int unsigned DimW         = 13;  // config register width
  localparam int unsigned CrdW         = 12;  // level coordinate width
  localparam int unsigned LvlW         = 4;
  localparam int unsigned PixW         = 32;
  localparam int unsigned SumW         = 40;  // four 10-bit pair sums
  localparam int unsigned QueueDepth   = 4;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [DimW-1:0] w;
    logic [DimW-1:0] h;
    logic [LvlW-1:0] n;  // number of output levels
  } mbfc_geom_t;

  typedef struct packed {
    logic [PixW-1:0] pix;
    logic [CrdW-1:0] x;
    logic [CrdW-1:0] y;
    logic            fin;  // caused by the last cropped base pixel
  } mbfc_item_t;

  function automatic logic [SumW-1:0] pair_sum(logic [PixW-1:0] a, logic [PixW-1:0] b);
    logic [SumW-1:0] s;
    s = '0;
    for (int c = 0; c < 4; c++) begin
      s[10*c +: 10] = 10'(a[8*c +: 8]) + 10'(b[8*c +: 8]);
    end
    return s;
  endfunction

  function automatic logic [PixW-1:0] quad_avg(logic [SumW-1:0] s0, logic [SumW-1:0] s1);
    logic [PixW-1:0] p;
    logic [10:0]     t;
    p = '0;
    for (int c = 0; c < 4; c++) begin
      t = 11'(s0[10*c +: 10]) + 11'(s1[10*c +: 10]);
      p[8*c +: 8] = t[9:2];
    end
    return p;
  endfunction

endpackage

// File: rtl/mbfc_front.sv
// Base level stage: pairs base pixels and emits level-1 pixels into the queue
module mbfc_front import mbfc_pkg::*; #(
  parameter int unsigned MAX_WIDTH = DefMaxWidth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clr_i,
  input  mbfc_geom_t        geom_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [PixW-1:0]   s_axis_tdata,
  output logic              push_o,
  output mbfc_item_t        push_item_o,
  input  logic              full_i
);

  localparam int unsigned HalfW = MAX_WIDTH / 2;
  localparam int unsigned AddrW = (HalfW > 1) ? $clog2(HalfW) : 1;

  logic [SumW-1:0] line_mem [HalfW];
  logic [SumW-1:0] rd_q;
  logic [PixW-1:0] left_q;
  logic [DimW-1:0] col_q, col_d, row_q, row_d;
  logic            s1_v_q, s1_v_d;
  logic [SumW-1:0] sum_q;
  logic [CrdW-1:0] x_q, y_q;
  logic            fin_q;
  logic            acc, in_reg, fin_px;
  logic [AddrW-1:0] addr;
  logic [DimW-1:0] w_even, h_even;

  assign w_even = {geom_i.w[DimW-1:1], 1'b0};
  assign h_even = {geom_i.h[DimW-1:1], 1'b0};
  assign acc    = s_axis_tvalid && s_axis_tready;
  assign in_reg = (geom_i.n != '0) && (col_q < w_even) && (row_q < h_even);
  assign fin_px = (geom_i.n != '0) && (col_q == w_even - 1'b1) && (row_q == h_even - 1'b1);
  assign addr   = AddrW'(col_q[DimW-1:1]);

  assign push_o        = s1_v_q && !full_i;
  assign s_axis_tready = !s1_v_q || !full_i;
  assign push_item_o   = '{pix: quad_avg(sum_q, rd_q), x: x_q, y: y_q, fin: fin_q};

  // even rows store pair sums, odd rows read them back
  always_ff @(posedge clk_i) begin
    if (acc && in_reg && col_q[0] && !row_q[0]) begin
      line_mem[addr] <= pair_sum(left_q, s_axis_tdata);
    end
    if (acc) begin
      rd_q <= line_mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && in_reg && !col_q[0]) begin
      left_q <= s_axis_tdata;
    end
    if (acc) begin
      sum_q <= pair_sum(left_q, s_axis_tdata);
      x_q   <= col_q[DimW-1:1];
      y_q   <= row_q[DimW-1:1];
      fin_q <= fin_px;
    end
  end

  always_comb begin
    s1_v_d = s1_v_q;
    if (acc) begin
      s1_v_d = in_reg && col_q[0] && row_q[0];
    end else if (push_o) begin
      s1_v_d = 1'b0;
    end
    col_d = col_q;
    row_d = row_q;
    if (clr_i) begin
      col_d = '0;
      row_d = '0;
    end else if (acc) begin
      if (col_q + 1'b1 >= geom_i.w) begin
        col_d = '0;
        row_d = (row_q + 1'b1 >= geom_i.h) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      col_q  <= '0;
      row_q  <= '0;
    end else begin
      s1_v_q <= s1_v_d;
      col_q  <= col_d;
      row_q  <= row_d;
    end
  end

endmodule

// File: rtl/mbfc_fifo.sv
// Short queue of level-1 pixels between base stage and cascade engine
module mbfc_fifo import mbfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  mbfc_item_t item_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output mbfc_item_t head_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  mbfc_item_t          slots_q [QueueDepth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [PtrW:0]       cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slots_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

endmodule

// File: rtl/mbfc_back.sv
// Cascade engine: emits one level pixel per cycle unless the output stalls, and builds the deeper levels
module mbfc_back import mbfc_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_LEVELS = DefMaxLevels
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mbfc_geom_t  geom_i,
  input  mbfc_item_t  head_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tlast,
  output logic        m_axis_tuser
);

  `include "mipmap_box_filter_chain_assert.svh"

  localparam int unsigned HalfW = MAX_WIDTH / 2;
  localparam int unsigned AddrW = (HalfW > 1) ? $clog2(HalfW) : 1;
  localparam int unsigned LIdxW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

  logic [SumW-1:0]  line_mem [HalfW];
  logic [PixW-1:0]  left_q [MAX_LEVELS];
  logic [SumW-1:0]  rd_q;
  logic             cur_v_q;
  mbfc_item_t       cur_q;
  logic [LvlW-1:0]  cur_lvl_q;
  logic             out_v_q, out_last_q, out_done_q;
  logic [63:0]      out_data_q;

  logic             can_go, in_reg, nxt_prod, load, issue;
  logic [DimW-1:0]  wl, hl, xe, ye;
  logic [PixW-1:0]  lpix, nxt_pix;
  logic [SumW-1:0]  psum;
  logic [LvlW-1:0]  rd_lvl;
  logic [CrdW-1:0]  rd_idx;
  logic [AddrW-1:0] raddr, waddr;

  function automatic logic [AddrW-1:0] region_addr(logic [LvlW-1:0] lvl, logic [CrdW-1:0] idx);
    return AddrW'(HalfW - (MAX_WIDTH >> lvl)) + AddrW'(idx);
  endfunction

  assign can_go   = cur_v_q && (!out_v_q || m_axis_tready);
  assign wl       = geom_i.w >> cur_lvl_q;
  assign hl       = geom_i.h >> cur_lvl_q;
  assign xe       = DimW'(cur_q.x);
  assign ye       = DimW'(cur_q.y);
  assign in_reg   = (cur_lvl_q < geom_i.n) && (xe < {wl[DimW-1:1], 1'b0})
                    && (ye < {hl[DimW-1:1], 1'b0});
  assign nxt_prod = in_reg && cur_q.x[0] && cur_q.y[0];
  assign lpix     = left_q[LIdxW'(cur_lvl_q)];
  assign psum     = pair_sum(lpix, cur_q.pix);
  assign nxt_pix  = quad_avg(psum, rd_q);
  assign load     = !cur_v_q || (can_go && !nxt_prod);
  assign pop_o    = load && !empty_i;
  assign issue    = pop_o || (can_go && nxt_prod);
  assign waddr    = region_addr(cur_lvl_q, cur_q.x >> 1);

  // read for the step that runs next; rd_q holds it while that step is stalled
  always_comb begin
    if (can_go && nxt_prod) begin
      rd_lvl = cur_lvl_q + 1'b1;
      rd_idx = cur_q.x >> 2;
    end else begin
      rd_lvl = LvlW'(1);
      rd_idx = head_i.x >> 1;
    end
  end
  assign raddr = region_addr(rd_lvl, rd_idx);

  always_ff @(posedge clk_i) begin
    if (can_go && in_reg && cur_q.x[0] && !cur_q.y[0]) begin
      line_mem[waddr] <= psum;
    end
    if (issue) begin
      rd_q <= line_mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_go && in_reg && !cur_q.x[0]) begin
      left_q[LIdxW'(cur_lvl_q)] <= cur_q.pix;
    end
    if (can_go && nxt_prod) begin
      cur_q <= '{pix: nxt_pix, x: cur_q.x >> 1, y: cur_q.y >> 1, fin: cur_q.fin};
    end else if (pop_o) begin
      cur_q <= head_i;
    end
    if (can_go) begin
      out_data_q <= {6'b0, cur_q.pix, cur_q.y[10:0], cur_q.x[10:0], cur_lvl_q};
      out_last_q <= !nxt_prod;
      out_done_q <= !nxt_prod && cur_q.fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q   <= 1'b0;
      cur_lvl_q <= '0;
      out_v_q   <= 1'b0;
    end else begin
      if (can_go && nxt_prod) begin
        cur_lvl_q <= cur_lvl_q + 1'b1;
      end else if (pop_o) begin
        cur_v_q   <= 1'b1;
        cur_lvl_q <= LvlW'(1);
      end else if (load) begin
        cur_v_q   <= 1'b0;
      end
      if (can_go) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_done_q;

  `MBF_ASSERT(a_done_is_last, out_v_q && out_done_q |-> out_last_q)
  `MBF_ASSERT(a_level_nonzero, cur_v_q |-> cur_lvl_q != '0)
  `MBF_ASSERT(a_cascade_step, can_go && nxt_prod |=> cur_v_q && cur_lvl_q == $past(cur_lvl_q) + 4'd1)
  `MBF_ASSERT_NEVER(a_pop_empty, pop_o && empty_i)

endmodule

// File: rtl/mipmap_box_filter_chain.sv
// Mip chain generator top level: config registers, base stage, queue, cascade engine
// Takes one BGRA base pixel per cycle in raster order and returns every mip level
// pixel as soon as its 2x2 block is complete, one result per cycle at most; a base
// pixel that completes a block of k levels yields k results from the cascade engine,
// which works one level per cycle against its own line memory while results are
// taken. A four-entry queue of level-1 pixels absorbs those bursts, so the input
// keeps its rate of one pixel per cycle as long as results are taken; only a cascade
// about ten or more levels deep on a very large image can back up the queue and
// stall the input. Width and height must be written only while idle, which the block
// itself does not enforce, and each write restarts the frame at pixel (0,0).
module mipmap_box_filter_chain import mbfc_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_LEVELS = DefMaxLevels
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [DimW-1:0] cfg_data_i,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [31:0]     s_axis_tdata,   // pixel_b, pixel_g, pixel_r, pixel_a
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [63:0]     m_axis_tdata,   // mip_level, out_x, out_y, out_b, out_g, out_r, out_a
  output logic            m_axis_tlast,
  output logic            m_axis_tuser    // frame_done
);

  logic [DimW-1:0] w_q, w_d, h_q, h_d;
  mbfc_geom_t      geom;
  logic            push, full, pop, empty;
  mbfc_item_t      push_item, head;

  always_comb begin
    w_d = w_q;
    h_d = h_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_WIDTH: begin
          if (cfg_data_i == '0) w_d = DimW'(1);
          else if (32'(cfg_data_i) > MAX_WIDTH) w_d = DimW'(MAX_WIDTH);
          else w_d = cfg_data_i;
        end
        REG_HEIGHT: begin
          if (cfg_data_i == '0) h_d = DimW'(1);
          else if (32'(cfg_data_i) > HeightLimit) h_d = DimW'(HeightLimit);
          else h_d = cfg_data_i;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= DimW'(1);
      h_q <= DimW'(1);
    end else begin
      w_q <= w_d;
      h_q <= h_d;
    end
  end

  // level count: last l with both halved dimensions nonzero
  always_comb begin
    geom.w = w_q;
    geom.h = h_q;
    geom.n = '0;
    for (int l = 1; l <= int'(MAX_LEVELS); l++) begin
      if (((w_q >> l) != '0) && ((h_q >> l) != '0)) geom.n = LvlW'(l);
    end
  end

  mbfc_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i, .rst_ni,
    .clr_i         (cfg_we_i),
    .geom_i        (geom),
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .push_o        (push),
    .push_item_o   (push_item),
    .full_i        (full)
  );

  mbfc_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  mbfc_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_LEVELS(MAX_LEVELS)) u_back (
    .clk_i, .rst_ni,
    .geom_i  (geom),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .m_axis_tuser
  );

endmodule

// File: test/tb_mipmap_box_filter_chain.sv
// Self-checking testbench for the mip chain box filter: directed frames, random frames, stalls
module tb_mipmap_box_filter_chain;
  timeunit 1ns;
  timeprecision 1ps;
  import mbfc_pkg::*;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainCycles = 40;

  typedef struct packed {
    logic [3:0]  lvl;
    logic [10:0] x;
    logic [10:0] y;
    logic [7:0]  b;
    logic [7:0]  g;
    logic [7:0]  r;
    logic [7:0]  a;
    logic        last;
    logic        done;
  } mip_px_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic            cfg_idx_i;
  logic [DimW-1:0] cfg_data_i;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [31:0]     s_axis_tdata;   // pixel_b, pixel_g, pixel_r, pixel_a
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [63:0]     m_axis_tdata;   // mip_level, out_x, out_y, out_b, out_g, out_r, out_a
  logic            m_axis_tlast;
  logic            m_axis_tuser;   // frame_done

  mipmap_box_filter_chain uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser
  );

  // predictor state
  logic [12:0]  img_w, img_h;
  logic [39:0]  pair_sums [4096];
  logic [31:0]  left_px [12];
  int unsigned  lvl_col [13];
  int unsigned  lvl_row [13];
  mip_px_t      pending_mips [$];

  int unsigned cycles, mismatches, mips_seen, pixels_sent, frames_done, deepest;
  bit          idle_en;
  bit          hold_req;

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned p;
    if (!idle_en) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned clamp_dim(logic [12:0] d);
    if (d == 0) return 1;
    if (d > 4096) return 4096;
    return d;
  endfunction

  // box filter cascade for one accepted base pixel
  task automatic predict_mips(logic [31:0] px_in);
    int unsigned w, h, n, lv, wl, hl, c0, r0, idx, addr, s, t;
    logic [31:0] px, nxt;
    logic [39:0] packed_sum;
    bit produced, final_px;
    mip_px_t burst [$];
    mip_px_t e;
    w = clamp_dim(img_w);
    h = clamp_dim(img_h);
    n = 0;
    while (n < 12 && (w >> (n + 1)) > 0 && (h >> (n + 1)) > 0) n++;
    final_px = n >= 1 && lvl_col[0] == 2 * (w >> 1) - 1 && lvl_row[0] == 2 * (h >> 1) - 1;
    px = px_in;
    lv = 0;
    forever begin
      wl = w >> lv;
      hl = h >> lv;
      c0 = lvl_col[lv];
      r0 = lvl_row[lv];
      produced = 0;
      nxt = '0;
      if (lv < n && c0 < (wl & ~1) && r0 < (hl & ~1)) begin
        if (!c0[0]) begin
          left_px[lv] = px;
        end else begin
          idx = c0 >> 1;
          addr = 4096 - (4096 >> lv) + idx;
          if (addr < 4096) begin
            packed_sum = '0;
            for (int c = 0; c < 4; c++) begin
              s = left_px[lv][8*c +: 8] + px[8*c +: 8];
              if (!r0[0]) begin
                packed_sum[10*c +: 10] = 10'(s);
              end else begin
                t = s + pair_sums[addr][10*c +: 10];
                nxt[8*c +: 8] = 8'(t >> 2);
              end
            end
            if (!r0[0]) begin
              pair_sums[addr] = packed_sum;
            end else begin
              e = '0;
              e.lvl = 4'(lv + 1);
              e.x = 11'(idx);
              e.y = 11'(r0 >> 1);
              {e.a, e.r, e.g, e.b} = nxt;
              burst.push_back(e);
              produced = 1;
              if (lv + 1 > deepest) deepest = lv + 1;
            end
          end
        end
      end
      if (c0 + 1 >= wl) begin
        lvl_col[lv] = 0;
        lvl_row[lv] = (r0 + 1 >= hl) ? 0 : r0 + 1;
      end else begin
        lvl_col[lv] = c0 + 1;
      end
      if (!produced || lv + 1 > 12) break;
      px = nxt;
      lv++;
    end
    if (burst.size() > 0) begin
      burst[burst.size()-1].last = 1'b1;
      burst[burst.size()-1].done = final_px;
    end
    foreach (burst[i]) pending_mips.push_back(burst[i]);
  endtask

  // result checker
  always @(posedge clk_i) begin
    mip_px_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.lvl = m_axis_tdata[3:0];
      got.x = m_axis_tdata[14:4];
      got.y = m_axis_tdata[25:15];
      got.b = m_axis_tdata[33:26];
      got.g = m_axis_tdata[41:34];
      got.r = m_axis_tdata[49:42];
      got.a = m_axis_tdata[57:50];
      got.last = m_axis_tlast;
      got.done = m_axis_tuser;
      mips_seen++;
      if (got.done === 1'b1) frames_done++;
      if (pending_mips.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", got);
      end else begin
        want = pending_mips.pop_front();
        if (got !== want || m_axis_tdata[63:58] !== 6'd0) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold on request
  initial begin
    int unsigned g;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 0;
      end
      g = pick_gap();
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  task automatic send_pixel(logic [31:0] px);
    int unsigned g;
    g = pick_gap();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_mips(px);
    pixels_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    wait (pending_mips.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [12:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_WIDTH) img_w = val; else img_h = val;
    for (int i = 0; i < 13; i++) begin
      lvl_col[i] = 0;
      lvl_row[i] = 0;
    end
  endtask

  task automatic set_size(logic [12:0] w, logic [12:0] h);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  task automatic send_random(int unsigned cnt);
    repeat (cnt) send_pixel($urandom());
  endtask

  // reset size is 1x1: no level exists, so nothing comes out
  task automatic test_tiny();
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h0000_0000);
    set_size(13'd0, 13'd0);
    send_random(2);
    set_size(13'd1, 13'd9);
    send_random(3);
  endtask

  // 4x4 with all-zero, all-ones and mixed blocks, then a second frame
  task automatic test_extremes();
    set_size(13'd4, 13'd4);
    for (int i = 0; i < 16; i++) send_pixel(i < 8 ? 32'hFFFF_FFFF : 32'h0000_0000);
    for (int i = 0; i < 16; i++) send_pixel((i % 3 == 0) ? 32'hFF00_FF00 : 32'h00FF_00FF);
  endtask

  // odd width and height drop their last column and row
  task automatic test_cropping();
    set_size(13'd5, 13'd3);
    send_random(15);
    set_size(13'd7, 13'd6);
    send_random(42);
  endtask

  // oversize registers saturate; only part of each frame is sent
  task automatic test_oversize();
    set_size(13'd8191, 13'd8191);
    send_random(8);
    set_size(13'd2, 13'd8191);
    send_random(10);
    set_size(13'd4096, 13'd1);
    send_random(6);
  endtask

  // long receiver hold while a dense frame keeps coming
  task automatic test_backpressure();
    set_size(13'd16, 13'd16);
    idle_en = 0;
    hold_req = 1;
    send_random(256);
    idle_en = 1;
  endtask

  task automatic test_random_frames();
    int unsigned w, h, sent;
    sent = 0;
    while (sent < 60) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(2, 8);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(2, 8);
      set_size(13'(w), 13'(h));
      idle_en = $urandom_range(0, 3) != 0;
      repeat ($urandom_range(1, 2)) begin
        send_random(clamp_dim(13'(w)) * clamp_dim(13'(h)));
        sent += clamp_dim(13'(w)) * clamp_dim(13'(h));
      end
      // occasionally cut a frame short
      if ($urandom_range(0, 3) == 0) begin
        send_random(5);
        sent += 5;
      end
    end
    idle_en = 1;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_WIDTH;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    img_w = 13'd1;
    img_h = 13'd1;
    for (int i = 0; i < 13; i++) begin
      lvl_col[i] = 0;
      lvl_row[i] = 0;
    end
    idle_en = 1;
    hold_req = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_tiny();
    test_extremes();
    test_cropping();
    test_oversize();
    test_backpressure();
    test_random_frames();
    drain();

    $display("sent %0d base pixels, checked %0d mip pixels", pixels_sent, mips_seen);
    $display("frames completed %0d, deepest level %0d, mismatches %0d",
             frames_done, deepest, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
